// ===== sv/idbsm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the idle dim / blank / suspend manager.
// Holds the item structs, mode and register codes and shared constants.
// No dependencies.
package idbsm_pkg;

	// Configuration port geometry
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned TIMEOUT_W = 16;

	// Idle time is compared in milliseconds; a 16-bit seconds timeout times 1000 fits here
	localparam int unsigned MS_W = 26;
	localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
	localparam logic [31:0] ACTIVE_LIMIT_MS = 32'd3000;

	// Item modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_DIM = 2'd0;
	localparam logic [1:0] REG_BLANK = 2'd1;
	localparam logic [1:0] REG_SUSPEND = 2'd2;
	localparam logic [1:0] REG_KEYBOARD = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] idle_ms;
		logic idle_inhibit;
		logic suspend_inhibit;
		logic battery_power;
	} tick_item_t;

	typedef struct packed {
		logic dim_on;
		logic dim_off;
		logic blank_on;
		logic blank_off;
		logic keyboard_light_off;
		logic keyboard_light_on;
		logic suspend_request;
		logic idle_status;
		logic dimmed_status;
		logic blanked_status;
	} result_item_t;

	// Configuration seen by the decision logic; thresholds are in milliseconds
	typedef struct packed {
		logic [MS_W-1:0] dim_ms;
		logic [MS_W-1:0] blank_ms;
		logic [MS_W-1:0] suspend_ms;
		logic keyboard_present;
		logic clr_fired;
	} cfg_t;

endpackage

// ===== sv/idbsm_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file with an APB-style port.
// Depends on idbsm_pkg for register codes and the cfg_t struct.
module idbsm_regs
	import idbsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [TIMEOUT_W-1:0] dim_timeout_q;
	logic [TIMEOUT_W-1:0] blank_timeout_q;
	logic [TIMEOUT_W-1:0] suspend_timeout_q;
	logic [MS_W-1:0] dim_ms_q;
	logic [MS_W-1:0] blank_ms_q;
	logic [MS_W-1:0] suspend_ms_q;
	logic keyboard_q;
	logic clr_q;
	logic wr_en;
	logic [1:0] reg_idx;
	logic [MS_W-1:0] wr_ms;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Written timeout converted to milliseconds once, at write time
	assign wr_ms = MS_W'(pwdata[TIMEOUT_W-1:0]) * MS_PER_S;

	// Register writes; a timeout write also raises clr_q to rearm all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_timeout_q <= '0;
			blank_timeout_q <= '0;
			suspend_timeout_q <= '0;
			dim_ms_q <= '0;
			blank_ms_q <= '0;
			suspend_ms_q <= '0;
			keyboard_q <= 1'b0;
			clr_q <= 1'b0;
		end else begin
			clr_q <= 1'b0;
			if (wr_en) begin
				case (reg_idx)
					REG_DIM: begin
						dim_timeout_q <= pwdata[TIMEOUT_W-1:0];
						dim_ms_q <= wr_ms;
						clr_q <= 1'b1;
					end
					REG_BLANK: begin
						blank_timeout_q <= pwdata[TIMEOUT_W-1:0];
						blank_ms_q <= wr_ms;
						clr_q <= 1'b1;
					end
					REG_SUSPEND: begin
						suspend_timeout_q <= pwdata[TIMEOUT_W-1:0];
						suspend_ms_q <= wr_ms;
						clr_q <= 1'b1;
					end
					REG_KEYBOARD: begin
						keyboard_q <= pwdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_DIM: prdata = DATA_W'(dim_timeout_q);
			REG_BLANK: prdata = DATA_W'(blank_timeout_q);
			REG_SUSPEND: prdata = DATA_W'(suspend_timeout_q);
			REG_KEYBOARD: prdata = DATA_W'(keyboard_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.dim_ms = dim_ms_q;
	assign cfg.blank_ms = blank_ms_q;
	assign cfg.suspend_ms = suspend_ms_q;
	assign cfg.keyboard_present = keyboard_q;
	assign cfg.clr_fired = clr_q;

endmodule

// ===== sv/idbsm_step.sv =====
`timescale 1ns / 1ps
// Decision logic and idle state: computes one result from one item and
// updates the state when the item moves on. Depends on idbsm_pkg.
module idbsm_step
	import idbsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  tick_item_t   item,
	input  cfg_t         cfg,
	output result_item_t result
);

	logic [31:0] prev_ms_q;
	logic dim_fired_q;
	logic blank_fired_q;
	logic susp_fired_q;
	logic seen_idle_q;
	logic idle_q;
	logic dimmed_q;
	logic blanked_q;

	logic [31:0] prev_ms_d;
	logic dim_fired_d;
	logic blank_fired_d;
	logic susp_fired_d;
	logic seen_idle_d;
	logic idle_d;
	logic dimmed_d;
	logic blanked_d;

	// Next state and pulses for the current item
	always_comb begin
		logic restore;
		logic active;
		logic [31:0] ms;

		ms = item.idle_ms;
		prev_ms_d = prev_ms_q;
		dim_fired_d = dim_fired_q;
		blank_fired_d = blank_fired_q;
		susp_fired_d = susp_fired_q;
		seen_idle_d = seen_idle_q;
		idle_d = idle_q;
		dimmed_d = dimmed_q;
		blanked_d = blanked_q;
		result = '0;
		restore = 1'b0;
		active = (ms < prev_ms_q) || (ms < ACTIVE_LIMIT_MS);

		case (item.mode)
			MODE_TICK: begin
				prev_ms_d = ms;
				if (active) begin
					restore = seen_idle_q || dimmed_q || blanked_q;
				end else if (!item.idle_inhibit) begin
					seen_idle_d = 1'b1;
					idle_d = 1'b1;
					if (!dim_fired_q && cfg.dim_ms != '0 && ms >= 32'(cfg.dim_ms)) begin
						result.dim_on = 1'b1;
						result.keyboard_light_off = cfg.keyboard_present;
						dimmed_d = 1'b1;
						dim_fired_d = 1'b1;
					end
					if (!blank_fired_q && cfg.blank_ms != '0 &&
					    ms >= 32'(cfg.blank_ms)) begin
						result.blank_on = 1'b1;
						blanked_d = 1'b1;
						blank_fired_d = 1'b1;
					end
					if (!susp_fired_q && item.battery_power && cfg.suspend_ms != '0 &&
					    ms >= 32'(cfg.suspend_ms) && !item.suspend_inhibit) begin
						result.suspend_request = 1'b1;
						susp_fired_d = 1'b1;
					end
				end
			end
			MODE_CANCEL: begin
				restore = 1'b1;
			end
			MODE_RESTART: begin
				restore = 1'b1;
				prev_ms_d = '0;
			end
			default: begin
			end
		endcase

		// Restore brings the display back and clears every stage
		if (restore) begin
			result.blank_off = blanked_q;
			result.dim_off = dimmed_q;
			result.keyboard_light_on = cfg.keyboard_present;
			blanked_d = 1'b0;
			dimmed_d = 1'b0;
			dim_fired_d = 1'b0;
			blank_fired_d = 1'b0;
			susp_fired_d = 1'b0;
			idle_d = 1'b0;
			seen_idle_d = 1'b0;
		end

		result.idle_status = idle_d;
		result.dimmed_status = dimmed_d;
		result.blanked_status = blanked_d;
	end

	// State registers; timeout writes rearm the stages unless an item moves on while clr_fired is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ms_q <= '0;
			dim_fired_q <= 1'b0;
			blank_fired_q <= 1'b0;
			susp_fired_q <= 1'b0;
			seen_idle_q <= 1'b0;
			idle_q <= 1'b0;
			dimmed_q <= 1'b0;
			blanked_q <= 1'b0;
		end else if (fire) begin
			prev_ms_q <= prev_ms_d;
			dim_fired_q <= dim_fired_d;
			blank_fired_q <= blank_fired_d;
			susp_fired_q <= susp_fired_d;
			seen_idle_q <= seen_idle_d;
			idle_q <= idle_d;
			dimmed_q <= dimmed_d;
			blanked_q <= blanked_d;
		end else if (cfg.clr_fired) begin
			dim_fired_q <= 1'b0;
			blank_fired_q <= 1'b0;
			susp_fired_q <= 1'b0;
		end
	end

endmodule

// ===== sv/idle_dim_blank_suspend_manager_unit.sv =====
`timescale 1ns / 1ps
// Idle dim / blank / suspend manager, top level.
// Channels: tick_valid/tick_stall/tick_item carry one item in; an item is
// taken at a clock edge where tick_valid is high and tick_stall is low.
// result_valid/result_stall/result_item carry one result per item out,
// taken the same way. Every item gives exactly one result, in order.
// Timeouts and the keyboard flag are set over the APB-style port while the
// block is idle; a timeout write rearms all stages unless an item moves on
// while the rearm pulse is high. The item sits in an input register, the
// decision logic works on it and the result lands in the output register,
// where the idle state is updated; result_valid rises once it is loaded.
// Throughput: one item per cycle when the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item; only then does tick_stall
// rise. Reset clears all state, the timeouts and both pipeline valid flags.
// Depends on idbsm_pkg, idbsm_regs and idbsm_step.
module idle_dim_blank_suspend_manager_unit
	import idbsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_item_t        tick_item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_item_t      result_item
);

	cfg_t cfg;
	tick_item_t item_s1;
	logic valid_s1;
	logic out_valid_q;
	result_item_t out_item_q;
	result_item_t step_res;
	logic advance;
	logic load_s1;
	logic fire;

	idbsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	idbsm_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	// Handshake control
	assign advance = !out_valid_q || !result_stall;
	assign fire = valid_s1 && advance;
	assign load_s1 = !valid_s1 || advance;
	assign tick_stall = !load_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && tick_valid) begin
			item_s1 <= tick_item;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= step_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item = out_item_q;

	// Checks on the decision logic and the pipeline control
	a_dim_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_item.dim_on && result_item.dim_off))
		else $error("dim_on and dim_off in one result");

	a_screen_implies_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result_item.dimmed_status && !result_item.blanked_status) ||
		                 result_item.idle_status)
		else $error("screen dimmed or blanked while not idle");

	a_blank_sets_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.blank_on |-> result_item.blanked_status)
		else $error("blank_on without blanked_status");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> valid_s1 && out_valid_q && result_stall)
		else $error("input stalled with room in the pipeline");

	a_held_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result_stall |=> result_valid)
		else $error("held item did not reach the output");

endmodule
